/* rtl/hbc_pkg.sv */
// Package for the hashed buffer cache: widths, codes and the entry record.
package hbc_pkg;

  localparam int NumEntries = 32;
  localparam int NumBuckets = 13;

  localparam int DevW   = 16;
  localparam int BlkW   = 31;
  localparam int IdxW   = 5;
  localparam int TickW  = 32;
  localparam int CntW   = 8;
  localparam int BktW   = 4;
  localparam int StampW = 32;
  localparam int OpW    = 2;
  localparam int StW    = 2;

  localparam logic [CntW-1:0] CountMax = '1;

  localparam logic [OpW-1:0] OpGet     = 2'd0;
  localparam logic [OpW-1:0] OpRelease = 2'd1;
  localparam logic [OpW-1:0] OpPin     = 2'd2;
  localparam logic [OpW-1:0] OpUnpin   = 2'd3;

  localparam logic [StW-1:0] StOk     = 2'd0;
  localparam logic [StW-1:0] StNoFree = 2'd1;
  localparam logic [StW-1:0] StUnder  = 2'd2;
  localparam logic [StW-1:0] StOver   = 2'd3;

  typedef struct packed {
    logic [DevW-1:0]   dev;
    logic [BlkW-1:0]   blk;
    logic              valid;
    logic [CntW-1:0]   cnt;
    logic [TickW-1:0]  last_use;
    logic [BktW-1:0]   bkt;
    logic [StampW-1:0] stamp;
  } entry_t;

endpackage

/* rtl/hbc_if.sv */
// Valid/ready channel interfaces for the request and the response side.
interface hbc_in_if;
  logic                          valid;
  logic                          ready;
  logic [hbc_pkg::OpW-1:0]       op;
  logic [hbc_pkg::DevW-1:0]      device;
  logic [hbc_pkg::BlkW-1:0]      block_number;
  logic [hbc_pkg::IdxW-1:0]      entry_index;
  logic [hbc_pkg::TickW-1:0]     now_tick;
  modport source (output valid, op, device, block_number, entry_index, now_tick,
                  input ready);
  modport sink (input valid, op, device, block_number, entry_index, now_tick,
                output ready);
endinterface

interface hbc_out_if;
  logic                      valid;
  logic                      ready;
  logic [hbc_pkg::IdxW-1:0]  result_entry;
  logic                      was_hit;
  logic                      need_read;
  logic [hbc_pkg::StW-1:0]   status;
  modport source (output valid, result_entry, was_hit, need_read, status,
                  input ready);
  modport sink (input valid, result_entry, was_hit, need_read, status,
                output ready);
endinterface

/* rtl/hashed_buffer_cache_lru.sv */
// Top level of the hashed buffer cache tag table with timestamp LRU.
//
//  channel | dir | payload                                        | handshake
//  in_i    | in  | op, device, block_number, entry_index, now_tick | valid/ready
//  out_o   | out | result_entry, was_hit, need_read, status        | valid/ready
//
// A get accepts the transaction in the idle state, reduces the block number to its
// bucket, makes a pass over the tag RAM, chooses an entry, searches the other
// buckets for one to steal from if its own has no free entry, and then reads,
// modifies and loads the result register. Release, pin and unpin only read,
// modify and load the result register, and an entry index beyond the table goes
// straight to the result. The single read port of the tag RAM sets the pass length.
// After reset every entry reads as its reset value through a per-entry written
// flag, so no clearing pass is needed. A new transaction is taken while the
// previous result still waits in the output register; a result waits only if
// that register is still full.
module hashed_buffer_cache_lru #(
  parameter int NUM_ENTRIES = hbc_pkg::NumEntries,
  parameter int NUM_BUCKETS = hbc_pkg::NumBuckets
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbc_in_if.sink     in_i,
  hbc_out_if.source  out_o
);

  localparam int IW   = $clog2(NUM_ENTRIES);
  localparam int NBkt = 1 << hbc_pkg::BktW;

  // Remainders of 2^8, 2^16 and 2^24 by the bucket count, and the reciprocal
  // used to divide the folded sum exactly.
  localparam int HashW1  = (1 << 8) % NUM_BUCKETS;
  localparam int HashW2  = (1 << 16) % NUM_BUCKETS;
  localparam int HashW3  = (1 << 24) % NUM_BUCKETS;
  localparam int HashMul = ((1 << 19) + NUM_BUCKETS - 1) / NUM_BUCKETS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HASH, ST_SCAN, ST_DRAIN, ST_CHOOSE, ST_STEAL,
    ST_READ, ST_MODIFY, ST_DONE
  } state_e;

  state_e state_q;

  // Captured request.
  logic [hbc_pkg::OpW-1:0]    op_q;
  logic [hbc_pkg::DevW-1:0]   dev_q;
  logic [hbc_pkg::BlkW-1:0]   blk_q;
  logic [hbc_pkg::TickW-1:0]  now_q;

  logic                       hcnt_q;
  logic [13:0]                hs_q;
  logic [hbc_pkg::BktW-1:0]   home_q;
  logic [IW-1:0]              scan_q;
  logic                       p_vld_q;
  logic [IW-1:0]              p_idx_q;

  logic                       hit_f_q;
  logic [IW-1:0]              hit_idx_q;
  logic [hbc_pkg::StampW-1:0] hit_age_q;

  // Oldest free entry found so far for each bucket.
  logic [NBkt-1:0]            bb_f_q;
  logic [IW-1:0]              bb_idx_q [NBkt];
  logic [hbc_pkg::TickW-1:0]  bb_lu_q  [NBkt];
  logic [hbc_pkg::StampW-1:0] bb_age_q [NBkt];
  logic [hbc_pkg::BktW-1:0]   cb_q;

  logic [IW-1:0]              pick_q;
  logic                       pick_hit_q;
  logic                       steal_q;
  logic [hbc_pkg::StampW-1:0] stamp_q;
  logic [NUM_ENTRIES-1:0]     written_q;

  logic [hbc_pkg::IdxW-1:0]   res_entry_q;
  logic                       res_hit_q, res_rd_q;
  logic [hbc_pkg::StW-1:0]    res_st_q;
  logic                       out_vld_q;
  logic [hbc_pkg::IdxW-1:0]   out_entry_q;
  logic                       out_hit_q, out_rd_q;
  logic [hbc_pkg::StW-1:0]    out_st_q;

  // Tag RAM port.
  logic                       ram_we;
  logic [IW-1:0]              ram_raddr, ram_waddr;
  hbc_pkg::entry_t            ram_wdata, ram_rdata;

  hbc_ram #(
    .Width ($bits(hbc_pkg::entry_t)),
    .Depth (NUM_ENTRIES)
  ) u_tags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read data, with never-written entries shown at their reset value.
  logic [IW-1:0]   rd_idx;
  hbc_pkg::entry_t ent;
  always_comb begin
    rd_idx = (state_q == ST_MODIFY) ? pick_q : p_idx_q;
    if (written_q[rd_idx]) begin
      ent = ram_rdata;
    end else begin
      ent = '0;
      ent.stamp = hbc_pkg::StampW'(rd_idx);
    end
  end

  // Bucket hash. Each byte weighted by the remainder of its place
  // value keeps the remainder of the block number and the sum stays below 2^14;
  // a reciprocal multiplication then gives the exact quotient of that sum.
  logic [13:0] hfold, hquo, hrem;
  logic [32:0] hprod;
  always_comb begin
    hfold = 14'(blk_q[7:0]) + 14'(blk_q[15:8]) * 14'(HashW1) +
            14'(blk_q[23:16]) * 14'(HashW2) + 14'(blk_q[30:24]) * 14'(HashW3);
    hprod = 33'(hs_q) * 33'(HashMul);
    hquo  = hprod[32:19];
    hrem  = hs_q - hquo * 14'(NUM_BUCKETS);
  end

  // Scan compare for the entry coming out of the RAM.
  logic [hbc_pkg::StampW-1:0] e_age;
  logic [hbc_pkg::BktW-1:0]   bsel;
  logic                       hit_upd, free_upd;
  always_comb begin
    e_age = stamp_q - ent.stamp;
    unique case (state_q)
      ST_CHOOSE: bsel = home_q;
      ST_STEAL:  bsel = cb_q;
      default:   bsel = ent.bkt;
    endcase
    hit_upd = p_vld_q && ent.bkt == home_q && ent.dev == dev_q && ent.blk == blk_q &&
              (!hit_f_q || e_age < hit_age_q);
    free_upd = p_vld_q && ent.cnt == '0 &&
               (!bb_f_q[bsel] || ent.last_use < bb_lu_q[bsel] ||
                (ent.last_use == bb_lu_q[bsel] && e_age < bb_age_q[bsel]));
  end

  // Read address and write-back of the chosen entry.
  logic [hbc_pkg::StW-1:0] m_st;
  logic                    m_rd;
  always_comb begin
    ram_raddr = scan_q;
    if (state_q == ST_READ) ram_raddr = pick_q;
    ram_waddr = pick_q;
    ram_wdata = ent;
    ram_we    = 1'b0;
    m_st      = hbc_pkg::StOk;
    m_rd      = 1'b0;
    if (state_q == ST_MODIFY) begin
      if (op_q == hbc_pkg::OpGet) begin
        if (pick_hit_q) begin
          if (ent.cnt == hbc_pkg::CountMax) begin
            m_st = hbc_pkg::StOver;
          end else begin
            ram_we = 1'b1;
            ram_wdata.cnt = ent.cnt + 1'b1;
            ram_wdata.valid = 1'b1;
            m_rd = !ent.valid;
          end
        end else begin
          ram_we = 1'b1;
          m_rd = 1'b1;
          ram_wdata.dev = dev_q;
          ram_wdata.blk = blk_q;
          ram_wdata.cnt = hbc_pkg::CntW'(1);
          ram_wdata.valid = 1'b1;
          if (steal_q) begin
            ram_wdata.bkt = home_q;
            ram_wdata.stamp = stamp_q;
          end
        end
      end else if (op_q == hbc_pkg::OpPin) begin
        if (ent.cnt == hbc_pkg::CountMax) begin
          m_st = hbc_pkg::StOver;
        end else begin
          ram_we = 1'b1;
          ram_wdata.cnt = ent.cnt + 1'b1;
        end
      end else if (ent.cnt == '0) begin
        m_st = hbc_pkg::StUnder;
      end else begin
        ram_we = 1'b1;
        ram_wdata.cnt = ent.cnt - 1'b1;
        // A release that drops the last reference records when it happened.
        if (op_q == hbc_pkg::OpRelease && ent.cnt == hbc_pkg::CntW'(1)) begin
          ram_wdata.last_use = now_q;
        end
      end
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_vld_q;
  assign out_o.result_entry = out_entry_q;
  assign out_o.was_hit      = out_hit_q;
  assign out_o.need_read    = out_rd_q;
  assign out_o.status       = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      written_q <= '0;
      stamp_q   <= hbc_pkg::StampW'(NUM_ENTRIES);
      p_vld_q   <= 1'b0;
      hit_f_q   <= 1'b0;
      bb_f_q    <= '0;
    end else begin
      // The output register fills from the done state and empties when taken.
      if (state_q == ST_DONE && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      p_vld_q <= (state_q == ST_SCAN);
      p_idx_q <= scan_q;
      if (hit_upd) begin
        hit_f_q   <= 1'b1;
        hit_idx_q <= p_idx_q;
        hit_age_q <= e_age;
      end
      if (free_upd) begin
        bb_f_q[bsel]   <= 1'b1;
        bb_idx_q[bsel] <= p_idx_q;
        bb_lu_q[bsel]  <= ent.last_use;
        bb_age_q[bsel] <= e_age;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q   <= in_i.op;
            dev_q  <= in_i.device;
            blk_q  <= in_i.block_number;
            now_q  <= in_i.now_tick;
            pick_q <= IW'(in_i.entry_index);
            pick_hit_q <= 1'b0;
            steal_q    <= 1'b0;
            hit_f_q    <= 1'b0;
            bb_f_q     <= '0;
            home_q     <= '0;
            hcnt_q     <= 1'b0;
            scan_q     <= '0;
            res_entry_q <= in_i.entry_index;
            res_hit_q   <= 1'b0;
            res_rd_q    <= 1'b0;
            res_st_q    <= hbc_pkg::StOk;
            if (in_i.op == hbc_pkg::OpGet) begin
              state_q <= ST_HASH;
            end else if (int'(in_i.entry_index) >= NUM_ENTRIES) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_HASH: begin
          hcnt_q <= 1'b1;
          if (!hcnt_q) begin
            hs_q <= hfold;
          end else begin
            home_q  <= hbc_pkg::BktW'(hrem);
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_q  <= scan_q + 1'b1;
          if (int'(scan_q) == NUM_ENTRIES - 1) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state_q <= ST_CHOOSE;
        end
        ST_CHOOSE: begin
          cb_q <= '0;
          if (hit_f_q) begin
            pick_q     <= hit_idx_q;
            pick_hit_q <= 1'b1;
            state_q    <= ST_READ;
          end else if (bb_f_q[bsel]) begin
            pick_q  <= bb_idx_q[bsel];
            state_q <= ST_READ;
          end else begin
            state_q <= ST_STEAL;
          end
        end
        ST_STEAL: begin
          cb_q <= cb_q + 1'b1;
          if (cb_q != home_q && bb_f_q[bsel]) begin
            pick_q  <= bb_idx_q[bsel];
            steal_q <= 1'b1;
            state_q <= ST_READ;
          end else if (int'(cb_q) == NUM_BUCKETS - 1) begin
            res_entry_q <= '0;
            res_st_q    <= hbc_pkg::StNoFree;
            state_q     <= ST_DONE;
          end
        end
        ST_READ: begin
          state_q <= ST_MODIFY;
        end
        ST_MODIFY: begin
          if (ram_we) written_q[pick_q] <= 1'b1;
          if (op_q == hbc_pkg::OpGet) begin
            res_entry_q <= hbc_pkg::IdxW'(pick_q);
            res_hit_q   <= pick_hit_q;
            if (steal_q) stamp_q <= stamp_q + 1'b1;
          end
          res_rd_q <= m_rd;
          res_st_q <= m_st;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_entry_q <= res_entry_q;
            out_hit_q   <= res_hit_q;
            out_rd_q    <= res_rd_q;
            out_st_q    <= res_st_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/hbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* bench/tb_hashed_buffer_cache_lru.sv */
// Testbench for the hashed buffer cache tag table: directed and random gets and count updates.
module tb_hashed_buffer_cache_lru;

  // One result as the block reports it.
  typedef struct packed {
    logic [hbc_pkg::IdxW-1:0] entry;
    logic                     hit;
    logic                     rd;
    logic [hbc_pkg::StW-1:0]  st;
  } grant_t;

  logic clk_i;
  logic rst_ni;
  hbc_in_if  req_ch ();
  hbc_out_if rsp_ch ();

  hashed_buffer_cache_lru DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (rsp_ch.source)
  );

  // Shadow copy of the tag table, kept in step with every accepted transaction.
  logic [hbc_pkg::DevW-1:0]   sh_dev   [hbc_pkg::NumEntries];
  logic [hbc_pkg::BlkW-1:0]   sh_blk   [hbc_pkg::NumEntries];
  logic                       sh_valid [hbc_pkg::NumEntries];
  logic [hbc_pkg::CntW-1:0]   sh_cnt   [hbc_pkg::NumEntries];
  logic [hbc_pkg::TickW-1:0]  sh_lru   [hbc_pkg::NumEntries];
  logic [hbc_pkg::BktW-1:0]   sh_bkt   [hbc_pkg::NumEntries];
  logic [hbc_pkg::StampW-1:0] sh_stamp [hbc_pkg::NumEntries];
  logic [hbc_pkg::StampW-1:0] sh_next_stamp;

  grant_t expected_grants[$];
  int     send_idle_pct;
  int     recv_idle_pct;
  int     errors = 0;
  longint cycles = 0;

  // Recently used tags so that random gets hit often.
  logic [hbc_pkg::DevW-1:0] seen_dev[$];
  logic [hbc_pkg::BlkW-1:0] seen_blk[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A generous watchdog on the whole run, allowing for both sides idling.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void shadow_reset();
    for (int e = 0; e < hbc_pkg::NumEntries; e++) begin
      sh_dev[e] = '0; sh_blk[e] = '0; sh_valid[e] = 1'b0; sh_cnt[e] = '0;
      sh_lru[e] = '0; sh_bkt[e] = '0; sh_stamp[e] = hbc_pkg::StampW'(e);
    end
    sh_next_stamp = hbc_pkg::StampW'(hbc_pkg::NumEntries);
  endfunction

  // Entry a is newer in its bucket list than entry b.
  function automatic bit is_newer(int a, int b);
    return (sh_next_stamp - sh_stamp[a]) < (sh_next_stamp - sh_stamp[b]);
  endfunction

  // Free entry of bucket bk with the oldest last-use; ties go to the newer insertion.
  function automatic int pick_victim(int bk);
    int best;
    best = -1;
    for (int e = 0; e < hbc_pkg::NumEntries; e++) begin
      if (sh_bkt[e] != bk || sh_cnt[e] != 0) continue;
      if (best < 0 || sh_lru[e] < sh_lru[best] ||
          (sh_lru[e] == sh_lru[best] && is_newer(e, best)))
        best = e;
    end
    return best;
  endfunction

  // Applies one transaction to the shadow table and returns the grant it must produce.
  function automatic grant_t predict_grant(logic [hbc_pkg::OpW-1:0] op,
                                           logic [hbc_pkg::DevW-1:0] dev,
                                           logic [hbc_pkg::BlkW-1:0] blk,
                                           logic [hbc_pkg::IdxW-1:0] idx,
                                           logic [hbc_pkg::TickW-1:0] now);
    grant_t g;
    int home, hit, pick;
    g = '0;
    if (op == hbc_pkg::OpGet) begin
      home = blk % hbc_pkg::NumBuckets;
      hit = -1;
      for (int e = 0; e < hbc_pkg::NumEntries; e++)
        if (sh_bkt[e] == home && sh_dev[e] == dev && sh_blk[e] == blk &&
            (hit < 0 || is_newer(e, hit)))
          hit = e;
      if (hit >= 0) begin
        g.entry = hbc_pkg::IdxW'(hit);
        g.hit = 1'b1;
        if (sh_cnt[hit] == hbc_pkg::CountMax) begin
          g.st = hbc_pkg::StOver;
        end else begin
          sh_cnt[hit]++;
          g.rd = !sh_valid[hit];
          sh_valid[hit] = 1'b1;
          g.st = hbc_pkg::StOk;
        end
        return g;
      end
      pick = pick_victim(home);
      if (pick < 0) begin
        // Steal from the first other bucket, in index order, that has a free entry.
        for (int bk = 0; bk < hbc_pkg::NumBuckets && pick < 0; bk++)
          if (bk != home) pick = pick_victim(bk);
        if (pick < 0) begin
          g.st = hbc_pkg::StNoFree;
          return g;
        end
        sh_bkt[pick] = hbc_pkg::BktW'(home);
        sh_stamp[pick] = sh_next_stamp;
        sh_next_stamp++;
      end
      sh_dev[pick] = dev; sh_blk[pick] = blk; sh_valid[pick] = 1'b1;
      sh_cnt[pick] = hbc_pkg::CntW'(1);
      g.entry = hbc_pkg::IdxW'(pick);
      g.rd = 1'b1;
      g.st = hbc_pkg::StOk;
      return g;
    end
    g.entry = idx;
    g.st = hbc_pkg::StOk;
    if (idx < hbc_pkg::NumEntries) begin
      if (op == hbc_pkg::OpPin) begin
        if (sh_cnt[idx] == hbc_pkg::CountMax) g.st = hbc_pkg::StOver;
        else sh_cnt[idx]++;
      end else if (sh_cnt[idx] == 0) begin
        g.st = hbc_pkg::StUnder;
      end else begin
        sh_cnt[idx]--;
        if (op == hbc_pkg::OpRelease && sh_cnt[idx] == 0) sh_lru[idx] = now;
      end
    end
    return g;
  endfunction

  // Sends one transaction, idling first at random, and records its expected grant.
  // Valid stays high after the accepting edge until the next call or the drain.
  task automatic send_request(logic [hbc_pkg::OpW-1:0] op, logic [hbc_pkg::DevW-1:0] dev,
                              logic [hbc_pkg::BlkW-1:0] blk, logic [hbc_pkg::IdxW-1:0] idx,
                              logic [hbc_pkg::TickW-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.device       <= dev;
    req_ch.block_number <= blk;
    req_ch.entry_index  <= idx;
    req_ch.now_tick     <= now;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    expected_grants.push_back(predict_grant(op, dev, blk, idx, now));
    if (op == hbc_pkg::OpGet && seen_dev.size() < 64) begin
      seen_dev.push_back(dev);
      seen_blk.push_back(blk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Receiver side: random stalls, compare each accepted grant with the oldest expectation.
  always @(posedge clk_i) begin
    grant_t got, exp_g;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.result_entry, rsp_ch.was_hit, rsp_ch.need_read, rsp_ch.status};
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected grant %h", $time, got);
          errors++;
        end else begin
          exp_g = expected_grants.pop_front();
          if (got !== exp_g) begin
            $display("%0t: grant mismatch expected entry=%0d hit=%0d rd=%0d st=%0d",
                     $time, exp_g.entry, exp_g.hit, exp_g.rd, exp_g.st);
            $display("%0t:   actual entry=%0d hit=%0d rd=%0d st=%0d",
                     $time, got.entry, got.hit, got.rd, got.st);
            errors++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stale reset tags: device 0, block 0 hits in bucket 0, and block 13 also hashes there.
  task automatic test_reset_tags();
    send_request(hbc_pkg::OpGet, 16'd0, 31'd0, '0, '0);
    send_request(hbc_pkg::OpGet, 16'd0, 31'd0, '0, '0);
    send_request(hbc_pkg::OpGet, 16'hFFFF, 31'h7FFF_FFFF, '0, '0);
    send_request(hbc_pkg::OpGet, 16'd1, 31'd13, '0, '0);
    send_request(hbc_pkg::OpGet, 16'd1, 31'd13, '0, '0);
  endtask

  // Count limits: unpin and release of a zero count, releases stamping ticks.
  task automatic test_count_limits();
    send_request(hbc_pkg::OpUnpin, '0, '0, 5'd31, '0);
    send_request(hbc_pkg::OpRelease, '0, '0, 5'd30, 32'hFFFF_FFFF);
    send_request(hbc_pkg::OpPin, '0, '0, 5'd30, '0);
    send_request(hbc_pkg::OpRelease, '0, '0, 5'd30, 32'hFFFF_FFFF);
    send_request(hbc_pkg::OpRelease, '0, '0, 5'd0, 32'd5);
    send_request(hbc_pkg::OpRelease, '0, '0, 5'd0, 32'd6);
    send_request(hbc_pkg::OpUnpin, '0, '0, 5'd0, 32'd0);
    send_request(hbc_pkg::OpRelease, '0, '0, 5'd0, 32'd7);
  endtask

  // Pin one entry to the top: overflow on pin and on a hit of the saturated entry.
  task automatic test_overflow();
    int e;
    send_request(hbc_pkg::OpGet, 16'h00AA, 31'd26, '0, '0);
    e = int'(expected_grants[$].entry);
    while (sh_cnt[e] != hbc_pkg::CountMax)
      send_request(hbc_pkg::OpPin, '0, '0, hbc_pkg::IdxW'(e), '0);
    send_request(hbc_pkg::OpPin, '0, '0, hbc_pkg::IdxW'(e), '0);
    send_request(hbc_pkg::OpGet, 16'h00AA, 31'd26, '0, '0);
    while (sh_cnt[e] != 0)
      send_request(hbc_pkg::OpUnpin, '0, '0, hbc_pkg::IdxW'(e), '0);
  endtask

  // Exhaust free entries so that gets steal and then report no free buffer.
  task automatic test_no_free();
    for (int i = 0; i < 34; i++)
      send_request(hbc_pkg::OpGet, 16'(16'h0100 + i), 31'(i * 7 + 100), '0, '0);
    for (int i = 0; i < hbc_pkg::NumEntries; i++)
      send_request(hbc_pkg::OpRelease, '0, '0, hbc_pkg::IdxW'(i), 32'($urandom_range(3)));
    for (int i = 0; i < hbc_pkg::NumEntries; i++)
      while (sh_cnt[i] != 0) send_request(hbc_pkg::OpUnpin, '0, '0, hbc_pkg::IdxW'(i), '0);
  endtask

  // Random mix: mostly gets of a small working set and releases of random entries.
  task automatic test_random(int n);
    int sel, k;
    logic [hbc_pkg::BlkW-1:0] blk;
    logic [hbc_pkg::DevW-1:0] dev;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        if (seen_dev.size() > 0 && $urandom_range(1)) begin
          k = $urandom_range(seen_dev.size() - 1);
          dev = seen_dev[k]; blk = seen_blk[k];
        end else if ($urandom_range(9) == 0) begin
          dev = 16'($urandom); blk = 31'($urandom);
        end else begin
          dev = 16'($urandom_range(3)); blk = 31'($urandom_range(60));
        end
        send_request(hbc_pkg::OpGet, dev, blk, 5'($urandom), 32'($urandom));
      end else if (sel < 80) begin
        send_request(hbc_pkg::OpRelease, 16'($urandom), 31'($urandom), 5'($urandom),
                     $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(4)));
      end else if (sel < 88) begin
        send_request(hbc_pkg::OpPin, 16'($urandom), 31'($urandom), 5'($urandom),
                     32'($urandom));
      end else begin
        send_request(hbc_pkg::OpUnpin, 16'($urandom), 31'($urandom), 5'($urandom),
                     32'($urandom));
      end
      if (seen_dev.size() >= 64) begin
        void'(seen_dev.pop_front());
        void'(seen_blk.pop_front());
      end
    end
  endtask

  initial begin
    send_idle_pct = 24;
    recv_idle_pct = 50;
    shadow_reset();
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = hbc_pkg::OpGet;
    req_ch.device = '0;
    req_ch.block_number = '0;
    req_ch.entry_index = '0;
    req_ch.now_tick = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_tags();
    test_count_limits();
    test_overflow();
    test_no_free();
    test_random(220);
    send_idle_pct = 50;
    recv_idle_pct = 24;
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(220);

    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* hashed_buffer_cache_lru.f */
rtl/hbc_pkg.sv
rtl/hbc_if.sv
rtl/hbc_ram.sv
rtl/hashed_buffer_cache_lru.sv
bench/tb_hashed_buffer_cache_lru.sv
